@@ hw/rtl/owbm_pkg.sv @@
`default_nettype none

package owbm_pkg;

    // default counter width for the tick counter
    localparam int COUNTER_WIDTH_DEF = 10;

    // configuration field widths
    localparam int RST_LEN_W  = 10;
    localparam int SLOT_LEN_W = 8;
    localparam int SHORT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // configuration reset values
    localparam logic [RST_LEN_W-1:0]  RESET_LOW_DEF     = 10'd500;
    localparam logic [RST_LEN_W-1:0]  RESET_RELEASE_DEF = 10'd500;
    localparam logic [SLOT_LEN_W-1:0] WRITE_SLOT_DEF    = 8'd60;
    localparam logic [SLOT_LEN_W-1:0] READ_RECOVERY_DEF = 8'd120;
    localparam logic [SHORT_W-1:0]    START_LOW_DEF     = 4'd1;
    localparam logic [SHORT_W-1:0]    SAMPLE_DELAY_DEF  = 4'd0;

    // bits in one byte transaction
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_RECOVERY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY  = 3'd5;

    // commands carried with each tick
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // bus sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_REL  = 3'd2,
        PH_W_START  = 3'd3,
        PH_W_DATA   = 3'd4,
        PH_R_START  = 3'd5,
        PH_R_SAMPLE = 3'd6,
        PH_R_RECOV  = 3'd7
    } t_phase;

    // timing configuration
    typedef struct packed {
        logic [RST_LEN_W-1:0]  reset_low;
        logic [RST_LEN_W-1:0]  reset_release;
        logic [SLOT_LEN_W-1:0] write_slot;
        logic [SLOT_LEN_W-1:0] read_recovery;
        logic [SHORT_W-1:0]    start_low;
        logic [SHORT_W-1:0]    sample_delay;
    } t_cfg;

    // per-tick result
    typedef struct packed {
        logic       drive_enable;
        logic       drive_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/owbm_core.sv @@
`default_nettype none

module owbm_core #(
    parameter int COUNTER_WIDTH = owbm_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire owbm_pkg::t_cmd  i_cmd,
    input  wire logic [7:0]      i_write_byte,
    input  wire logic            i_line_level,
    input  wire owbm_pkg::t_cfg  i_cfg,
    output owbm_pkg::t_result    o_res
);

    localparam int LW = (COUNTER_WIDTH > owbm_pkg::RST_LEN_W) ?
                        COUNTER_WIDTH : owbm_pkg::RST_LEN_W;
    localparam logic [LW-1:0] CAP = LW'((1 << COUNTER_WIDTH) - 1);

    owbm_pkg::t_phase           r_phase, n_phase;
    owbm_pkg::t_cmd             r_op, n_op;
    logic [3:0]                 r_bits, n_bits;
    logic [7:0]                 r_shift, n_shift;
    logic [COUNTER_WIDTH-1:0]   r_tick, n_tick;

    // phase length to counter load: zero acts as one, saturate to counter
    function automatic logic [COUNTER_WIDTH-1:0] load_len(
        input logic [owbm_pkg::RST_LEN_W-1:0] len
    );
        logic [owbm_pkg::RST_LEN_W-1:0] lm1;
        logic [LW-1:0]                  ext;
        lm1 = (len == '0) ? '0 : len - 1'b1;
        ext = LW'(lm1);
        if (ext > CAP) begin
            ext = CAP;
        end
        return COUNTER_WIDTH'(ext);
    endfunction

    // one tick of the sequencer
    always_comb begin
        logic finish;
        n_phase = r_phase;
        n_op    = r_op;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_tick  = r_tick;
        o_res   = '0;
        finish  = 1'b0;

        // command start, only from idle
        if (r_phase == owbm_pkg::PH_IDLE && i_cmd != owbm_pkg::CMD_NONE) begin
            n_op = i_cmd;
            unique case (i_cmd)
                owbm_pkg::CMD_RESET: begin
                    n_phase = owbm_pkg::PH_RST_LOW;
                    n_tick  = load_len(i_cfg.reset_low);
                end
                owbm_pkg::CMD_WRITE: begin
                    n_shift = i_write_byte;
                    n_bits  = owbm_pkg::BYTE_BITS;
                    n_phase = owbm_pkg::PH_W_START;
                    n_tick  = load_len(10'(i_cfg.start_low));
                end
                default: begin
                    n_shift = '0;
                    n_bits  = owbm_pkg::BYTE_BITS;
                    n_phase = owbm_pkg::PH_R_START;
                    n_tick  = load_len(10'(i_cfg.start_low));
                end
            endcase
        end

        if (n_phase != owbm_pkg::PH_IDLE) begin
            o_res.busy_res = 1'b1;

            // line drive for this tick
            if (n_phase == owbm_pkg::PH_RST_LOW || n_phase == owbm_pkg::PH_W_START ||
                n_phase == owbm_pkg::PH_R_START) begin
                o_res.drive_enable = 1'b1;
            end else if (n_phase == owbm_pkg::PH_W_DATA) begin
                o_res.drive_enable = 1'b1;
                o_res.drive_level  = n_shift[0];
            end

            // count down or move to the next phase
            if (n_tick != '0) begin
                n_tick = n_tick - 1'b1;
            end else begin
                unique case (n_phase)
                    owbm_pkg::PH_RST_LOW: begin
                        n_phase = owbm_pkg::PH_RST_REL;
                        n_tick  = load_len(i_cfg.reset_release);
                    end
                    owbm_pkg::PH_RST_REL: begin
                        finish = 1'b1;
                    end
                    owbm_pkg::PH_W_START: begin
                        n_phase = owbm_pkg::PH_W_DATA;
                        n_tick  = load_len(10'(i_cfg.write_slot));
                    end
                    owbm_pkg::PH_W_DATA: begin
                        n_shift = {1'b0, n_shift[7:1]};
                        if (n_bits <= 4'd1) begin
                            n_bits = '0;
                            finish = 1'b1;
                        end else begin
                            n_bits  = n_bits - 1'b1;
                            n_phase = owbm_pkg::PH_W_START;
                            n_tick  = load_len(10'(i_cfg.start_low));
                        end
                    end
                    owbm_pkg::PH_R_START: begin
                        n_phase = owbm_pkg::PH_R_SAMPLE;
                        n_tick  = load_len(10'(i_cfg.sample_delay) + 10'd1);
                    end
                    owbm_pkg::PH_R_SAMPLE: begin
                        n_shift = {i_line_level, n_shift[7:1]};
                        n_phase = owbm_pkg::PH_R_RECOV;
                        n_tick  = load_len(10'(i_cfg.read_recovery));
                    end
                    default: begin
                        if (n_bits <= 4'd1) begin
                            n_bits = '0;
                            finish = 1'b1;
                        end else begin
                            n_bits  = n_bits - 1'b1;
                            n_phase = owbm_pkg::PH_R_START;
                            n_tick  = load_len(10'(i_cfg.start_low));
                        end
                    end
                endcase

                // operation complete
                if (finish) begin
                    o_res.done_res = 1'b1;
                    if (n_op == owbm_pkg::CMD_READ) begin
                        o_res.read_byte = n_shift;
                    end
                    n_phase = owbm_pkg::PH_IDLE;
                    n_tick  = '0;
                    n_op    = owbm_pkg::CMD_NONE;
                end
            end
        end
    end

    // sequencer state, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= owbm_pkg::PH_IDLE;
            r_op    <= owbm_pkg::CMD_NONE;
            r_bits  <= '0;
            r_shift <= '0;
            r_tick  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_tick  <= n_tick;
        end
    end

    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == owbm_pkg::PH_IDLE) |-> (r_tick == '0 && r_op == owbm_pkg::CMD_NONE))
        else $error("idle with running counter or operation");

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bits <= owbm_pkg::BYTE_BITS))
        else $error("bit count out of range");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_res.done_res || o_res.busy_res) && (!o_res.drive_level || o_res.drive_enable))
        else $error("done without busy or level without drive");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.done_res) |=> (r_phase == owbm_pkg::PH_IDLE))
        else $error("sequencer not idle after done");

endmodule

`default_nettype wire

@@ hw/rtl/owbm_skid.sv @@
`default_nettype none

module owbm_skid (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire owbm_pkg::t_result  i_data,
    output logic                    o_full,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output owbm_pkg::t_result       o_data
);

    owbm_pkg::t_result r_q0, r_q1;
    logic [1:0]        r_cnt;
    logic              pop;

    assign pop     = o_valid && !i_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_q0;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    // two-entry buffer, head in r_q0
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q0 <= (i_push && r_cnt == 2'd1) ? i_data : r_q1;
            if (i_push && r_cnt == 2'd2) begin
                r_q1 <= i_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= i_data;
            end else begin
                r_q1 <= i_data;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3) && !(o_full && i_push))
        else $error("output buffer overflow");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_q0)))
        else $error("stalled transaction lost");

endmodule

`default_nettype wire

@@ hw/rtl/one_wire_byte_master.sv @@
`default_nettype none

// One-wire byte master. Each input transaction is one bus tick (normally one
// microsecond) carrying an optional command (reset pulse, write byte, read
// byte), the byte to send and the sampled DQ level; each tick produces exactly
// one result transaction with the line drive, busy, done and the read byte.
// A command is taken only while idle and its first tick is the tick that
// carries it; commands given while busy are ignored. Bytes go out and come in
// least significant bit first. One tick is accepted every clock cycle unless
// the output buffer is full; each result is registered into a two-entry
// output buffer, so input stall rises only when two results are waiting. The
// user writes timing registers via the config port only while idle (the
// block does not enforce this); they apply from the next phase entered; a
// zero length acts as one and lengths beyond the tick counter saturate.

module one_wire_byte_master #(
    parameter int COUNTER_WIDTH = owbm_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [owbm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [owbm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // tick input
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [1:0]                       i_cmd,
    input  wire logic [7:0]                       i_write_byte,
    input  wire logic                             i_line_level,
    // result output
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_drive_enable,
    output logic                                  o_drive_level,
    output logic                                  o_busy_res,
    output logic                                  o_done_res,
    output logic [7:0]                            o_read_byte
);

    owbm_pkg::t_cfg    r_cfg;
    owbm_pkg::t_result step_res;
    owbm_pkg::t_result out_res;
    logic              accept;
    logic              full;

    assign accept     = i_in_valid && !full;
    assign o_in_stall = full;

    // timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= owbm_pkg::RESET_LOW_DEF;
            r_cfg.reset_release <= owbm_pkg::RESET_RELEASE_DEF;
            r_cfg.write_slot    <= owbm_pkg::WRITE_SLOT_DEF;
            r_cfg.read_recovery <= owbm_pkg::READ_RECOVERY_DEF;
            r_cfg.start_low     <= owbm_pkg::START_LOW_DEF;
            r_cfg.sample_delay  <= owbm_pkg::SAMPLE_DELAY_DEF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                owbm_pkg::CFG_RESET_LOW:     r_cfg.reset_low     <= i_cfg_data;
                owbm_pkg::CFG_RESET_RELEASE: r_cfg.reset_release <= i_cfg_data;
                owbm_pkg::CFG_WRITE_SLOT:    r_cfg.write_slot    <= i_cfg_data[7:0];
                owbm_pkg::CFG_READ_RECOVERY: r_cfg.read_recovery <= i_cfg_data[7:0];
                owbm_pkg::CFG_START_LOW:     r_cfg.start_low     <= i_cfg_data[3:0];
                owbm_pkg::CFG_SAMPLE_DELAY:  r_cfg.sample_delay  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // bus sequencer
    owbm_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_cmd        (owbm_pkg::t_cmd'(i_cmd)),
        .i_write_byte (i_write_byte),
        .i_line_level (i_line_level),
        .i_cfg        (r_cfg),
        .o_res        (step_res)
    );

    // result buffer
    owbm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (step_res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_drive_enable = out_res.drive_enable;
    assign o_drive_level  = out_res.drive_level;
    assign o_busy_res     = out_res.busy_res;
    assign o_done_res     = out_res.done_res;
    assign o_read_byte    = out_res.read_byte;

endmodule

`default_nettype wire
